FILE: hw/rtl/hgsp_pkg.sv
`default_nettype none

package hgsp_pkg;

  localparam int unsigned STRENGTH_W = 17;
  localparam int unsigned UV_W       = 17;
  localparam int unsigned COLOR_W    = 15;
  localparam int unsigned OUT_W      = 16;
  localparam int unsigned SUV_W      = 19;  // shifted uv, signed
  localparam int unsigned DELTA_W    = 16;  // aberration deltas and noise, signed
  localparam int unsigned SHAKE_T_W  = 15;
  localparam int unsigned GRAIN_T_W  = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // stage counts of the three pipeline sections
  localparam int unsigned SHAKE_STAGES = 6;
  localparam int unsigned GRAIN_STAGES = 5;
  localparam int unsigned PIPE_DEPTH   = SHAKE_STAGES + GRAIN_STAGES + 1;

  localparam logic [STRENGTH_W-1:0] ONE_UV = 17'h1_0000;

  localparam logic [31:0] HASH_M1 = 32'h9E37_79B9;
  localparam logic [31:0] HASH_M2 = 32'h85EB_CA6B;
  localparam logic [31:0] HASH_M3 = 32'hC2B2_AE35;
  localparam logic [31:0] HASH_M4 = 32'h7FEB_352D;
  localparam logic [31:0] HASH_M5 = 32'h846C_A68B;
  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

  // fixed salt terms of the two shake hashes, wrapped to 32 bits
  localparam logic [31:0] SALT_U = 32'h17 * HASH_M2 + 32'h3C * HASH_M3;
  localparam logic [31:0] SALT_V = 32'h29 * HASH_M2 + 32'h91 * HASH_M3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ABERRATION = 3'd0,
    REG_GRAIN      = 3'd1,
    REG_SHAKE      = 3'd2,
    REG_FRAME      = 3'd3,
    REG_SEED       = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [STRENGTH_W-1:0] ab;
    logic [STRENGTH_W-1:0] gr;
    logic [STRENGTH_W-1:0] sh;
    logic [31:0]           k;
  } cfg_t;

  typedef struct packed {
    logic signed [COLOR_W-1:0] r;
    logic signed [COLOR_W-1:0] g;
    logic signed [COLOR_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic signed [SUV_W-1:0] su;
    logic signed [SUV_W-1:0] sv;
    rgb_t                    rgb;
  } shake_word_t;

  typedef struct packed {
    rgb_t                      rgb;
    logic signed [DELTA_W-1:0] rd;
    logic signed [DELTA_W-1:0] bd;
    logic [GRAIN_T_W-1:0]      t;
    logic                      neg;
  } grain_word_t;

  function automatic logic [STRENGTH_W-1:0] clamp_strength(input logic [STRENGTH_W-1:0] x);
    return (x > ONE_UV) ? ONE_UV : x;
  endfunction

  // floor(t / 5) for t below 2^16
  function automatic logic [15:0] div5(input logic [15:0] t);
    logic [31:0] p;
    p = {16'd0, t} * 32'h0000_CCCD;
    return 16'(p >> 18);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/hgsp_if.sv
`default_nettype none

interface hgsp_pix_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [hgsp_pkg::UV_W-1:0]            u_coord;
  logic [hgsp_pkg::UV_W-1:0]            v_coord;
  logic signed [hgsp_pkg::COLOR_W-1:0]  red_in;
  logic signed [hgsp_pkg::COLOR_W-1:0]  green_in;
  logic signed [hgsp_pkg::COLOR_W-1:0]  blue_in;

  modport source (output valid, u_coord, v_coord, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, u_coord, v_coord, red_in, green_in, blue_in, output ready);
endinterface

interface hgsp_pix_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [hgsp_pkg::OUT_W-1:0]  red_out;
  logic signed [hgsp_pkg::OUT_W-1:0]  green_out;
  logic signed [hgsp_pkg::OUT_W-1:0]  blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/hgsp_hash.sv
`default_nettype none

// two registered multiply rounds of the hash finalizer; last xorshift is combinational
module hgsp_hash (
  input  logic        clk,
  input  logic [1:0]  en,
  input  logic [31:0] h0,
  output logic [31:0] h
);
  import hgsp_pkg::*;

  logic [31:0] x1, x2, m1, m2;

  assign x1 = h0 ^ (h0 >> 16);
  assign x2 = m1 ^ (m1 >> 15);
  assign h  = m2 ^ (m2 >> 16);

  always_ff @(posedge clk) begin
    if (en[0]) m1 <= x1 * HASH_M4;
    if (en[1]) m2 <= x2 * HASH_M5;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/hgsp_shake.sv
`default_nettype none

// shake offset: hash of the frame key, scaled by strength, added to uv
module hgsp_shake (
  input  logic                  clk,
  input  logic                  rst,
  input  hgsp_pkg::cfg_t        cfg,
  hgsp_pix_in_if.sink           pix_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hgsp_pkg::shake_word_t out_word
);
  import hgsp_pkg::*;

  localparam int unsigned NS = SHAKE_STAGES;

  logic [NS-1:0] vld, load;

  logic [UV_W-1:0] u_d [0:NS-2];
  logic [UV_W-1:0] v_d [0:NS-2];
  rgb_t            c_d [0:NS-2];

  logic [31:0]        ka, hu, hv;
  logic signed [49:0] pu, pv;
  logic [49:0]        mag_u, mag_v;
  logic [SHAKE_T_W-1:0] tu, tv;
  logic               nu, nv;
  logic [15:0]        qu, qv;
  logic signed [SUV_W-1:0] off_u, off_v;

  always_comb begin
    load[NS-1] = !vld[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) load[i] = !vld[i] || load[i+1];
  end

  assign pix_in.ready = load[0];
  assign out_valid    = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) vld[0] <= pix_in.valid;
      for (int i = 1; i < NS; i++) if (load[i]) vld[i] <= vld[i-1];
    end
  end

  hgsp_hash hash_u (.clk(clk), .en(load[2:1]), .h0(ka + SALT_U), .h(hu));
  hgsp_hash hash_v (.clk(clk), .en(load[2:1]), .h0(ka + SALT_V), .h(hv));

  // rounding of p / (5 * 2^33): add half, shift, then divide by five
  always_comb begin
    mag_u = pu[49] ? 50'(-pu) : 50'(pu);
    mag_v = pv[49] ? 50'(-pv) : 50'(pv);
    qu    = div5({1'b0, tu});
    qv    = div5({1'b0, tv});
    off_u = nu ? -SUV_W'(qu) : SUV_W'(qu);
    off_v = nv ? -SUV_W'(qv) : SUV_W'(qv);
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      u_d[0] <= pix_in.u_coord;
      v_d[0] <= pix_in.v_coord;
      c_d[0] <= '{r: pix_in.red_in, g: pix_in.green_in, b: pix_in.blue_in};
      ka     <= cfg.k * HASH_M1;
    end
    for (int i = 1; i < NS - 1; i++) begin
      if (load[i]) begin
        u_d[i] <= u_d[i-1];
        v_d[i] <= v_d[i-1];
        c_d[i] <= c_d[i-1];
      end
    end
    if (load[3]) begin
      pu <= $signed(hu ^ SIGN_BIT) * $signed({1'b0, cfg.sh});
      pv <= $signed(hv ^ SIGN_BIT) * $signed({1'b0, cfg.sh});
    end
    if (load[4]) begin
      tu <= SHAKE_T_W'((mag_u + (50'd5 << 32)) >> 33);
      tv <= SHAKE_T_W'((mag_v + (50'd5 << 32)) >> 33);
      nu <= pu[49];
      nv <= pv[49];
    end
    if (load[5]) begin
      out_word.su  <= $signed(SUV_W'(u_d[4])) + off_u;
      out_word.sv  <= $signed(SUV_W'(v_d[4])) + off_v;
      out_word.rgb <= c_d[4];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/hgsp_grain.sv
`default_nettype none

// aberration deltas and grain hash of the shifted uv cell
module hgsp_grain (
  input  logic                  clk,
  input  logic                  rst,
  input  hgsp_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hgsp_pkg::shake_word_t in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hgsp_pkg::grain_word_t out_word
);
  import hgsp_pkg::*;

  localparam int unsigned NG = GRAIN_STAGES;

  logic [NG-1:0] vld, load;

  rgb_t                      c_d  [0:NG-2];
  logic signed [DELTA_W-1:0] rd_d [1:NG-2];
  logic signed [DELTA_W-1:0] bd_d [1:NG-2];

  logic signed [20:0] dx, dy, bsum;
  logic [31:0]        gx, gy, ga, gb, kc, hg;
  logic signed [38:0] rp, bp;
  logic [38:0]        mag_r, mag_b, q_r, q_b;
  logic signed [49:0] pg;
  logic signed [51:0] p3;
  logic [51:0]        mag_g;

  always_comb begin
    load[NG-1] = !vld[NG-1] || out_ready;
    for (int i = NG - 2; i >= 0; i--) load[i] = !vld[i] || load[i+1];
  end

  assign in_ready  = load[0];
  assign out_valid = vld[NG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) vld[0] <= in_valid;
      for (int i = 1; i < NG; i++) if (load[i]) vld[i] <= vld[i-1];
    end
  end

  always_comb begin
    dx   = $signed({{2{in_word.su[SUV_W-1]}}, in_word.su}) - 21'sd32768;
    dy   = $signed({{2{in_word.sv[SUV_W-1]}}, in_word.sv}) - 21'sd32768;
    bsum = (dx <<< 2) + dy;
    // negative shifted coordinate maps to grain cell zero
    gx   = in_word.su[SUV_W-1] ? 32'd0 : {18'd0, in_word.su[17:4]};
    gy   = in_word.sv[SUV_W-1] ? 32'd0 : {18'd0, in_word.sv[17:4]};
    mag_r = rp[38] ? 39'(-rp) : 39'(rp);
    mag_b = bp[38] ? 39'(-bp) : 39'(bp);
    q_r   = (mag_r + (39'd1 << 19)) >> 20;
    q_b   = (mag_b + (39'd1 << 21)) >> 22;
    p3    = {{2{pg[49]}}, pg} + {pg[49], pg, 1'b0};
    mag_g = p3[51] ? 52'(-p3) : 52'(p3);
  end

  hgsp_hash hash_g (.clk(clk), .en(load[2:1]), .h0(ga + gb + kc), .h(hg));

  always_ff @(posedge clk) begin
    if (load[0]) begin
      rp     <= dx * $signed({1'b0, cfg.ab});
      bp     <= bsum * $signed({1'b0, cfg.ab});
      ga     <= gx * HASH_M1;
      gb     <= gy * HASH_M2;
      kc     <= cfg.k * HASH_M3;
      c_d[0] <= in_word.rgb;
    end
    if (load[1]) begin
      rd_d[1] <= rp[38] ? -DELTA_W'(q_r) : DELTA_W'(q_r);
      bd_d[1] <= bp[38] ? -DELTA_W'(q_b) : DELTA_W'(q_b);
      c_d[1]  <= c_d[0];
    end
    for (int i = 2; i < NG - 1; i++) begin
      if (load[i]) begin
        rd_d[i] <= rd_d[i-1];
        bd_d[i] <= bd_d[i-1];
        c_d[i]  <= c_d[i-1];
      end
    end
    if (load[3]) pg <= $signed(hg ^ SIGN_BIT) * $signed({1'b0, cfg.gr});
    if (load[4]) begin
      // 3 * p / (5 * 2^37), rounded: add half, shift, divide by five later
      out_word.t   <= GRAIN_T_W'((mag_g + (52'd5 << 36)) >> 37);
      out_word.neg <= p3[51];
      out_word.rd  <= rd_d[3];
      out_word.bd  <= bd_d[3];
      out_word.rgb <= c_d[3];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/hgsp_out.sv
`default_nettype none

// final noise scale, channel sums and saturation into the output register
module hgsp_out (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hgsp_pkg::grain_word_t in_word,
  hgsp_pix_out_if.source        pix_out
);
  import hgsp_pkg::*;

  logic [15:0]               q;
  logic signed [DELTA_W-1:0] noise;
  logic signed [17:0]        r_sum, g_sum, b_sum;

  function automatic logic signed [OUT_W-1:0] sat16(input logic signed [17:0] x);
    if (x > 18'sd32767)  return 16'sh7FFF;
    if (x < -18'sd32768) return 16'sh8000;
    return OUT_W'(x);
  endfunction

  always_comb begin
    q     = div5({4'd0, in_word.t});
    noise = in_word.neg ? -DELTA_W'(q) : DELTA_W'(q);
    r_sum = 18'(in_word.rgb.r) + 18'(in_word.rd) + 18'(noise);
    g_sum = 18'(in_word.rgb.g) + 18'(noise);
    b_sum = 18'(in_word.rgb.b) - 18'(in_word.bd) + 18'(noise);
  end

  assign in_ready = !pix_out.valid || pix_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (in_ready) begin
      pix_out.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      pix_out.red_out   <= sat16(r_sum);
      pix_out.green_out <= sat16(g_sum);
      pix_out.blue_out  <= sat16(b_sum);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/hashed_grain_shake_pixel_post_core.sv
`default_nettype none

// channel   dir  word
// pix_in    in   u_coord, v_coord, red_in, green_in, blue_in
// pix_out   out  red_out, green_out, blue_out
// cfg       in   cfg_we, cfg_index, cfg_data (write only)
//
// one pixel per clock sustained while the output is not stalled; 12 register stages
// (shake 6, grain 5, output 1).
// rst is synchronous and clears all stage valid bits and the config registers.
// each stage holds its word while the next is full, so bubbles are squeezed out;
// input ready drops only when every stage holds a word and the output is stalled.

module hashed_grain_shake_pixel_post_core (
  input  logic                                 clk,
  input  logic                                 rst,
  hgsp_pix_in_if.sink                          pix_in,
  hgsp_pix_out_if.source                       pix_out,
  input  logic                                 cfg_we,
  input  logic [hgsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hgsp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import hgsp_pkg::*;

  logic [STRENGTH_W-1:0] ab_raw, gr_raw, sh_raw;
  logic [31:0]           frame_lo, seed_lo;
  cfg_t                  cfg;

  logic        sh_valid, sh_ready, gr_valid, gr_ready;
  shake_word_t sh_word;
  grain_word_t gr_word;

  // only the low 32 bits of seed xor frame reach the hashes
  always_ff @(posedge clk) begin
    if (rst) begin
      ab_raw   <= '0;
      gr_raw   <= '0;
      sh_raw   <= '0;
      frame_lo <= '0;
      seed_lo  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_ABERRATION: ab_raw   <= cfg_data[STRENGTH_W-1:0];
        REG_GRAIN:      gr_raw   <= cfg_data[STRENGTH_W-1:0];
        REG_SHAKE:      sh_raw   <= cfg_data[STRENGTH_W-1:0];
        REG_FRAME:      frame_lo <= cfg_data[31:0];
        REG_SEED:       seed_lo  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign cfg.ab = clamp_strength(ab_raw);
  assign cfg.gr = clamp_strength(gr_raw);
  assign cfg.sh = clamp_strength(sh_raw);
  assign cfg.k  = frame_lo ^ seed_lo;

  hgsp_shake u_shake (
    .clk(clk), .rst(rst), .cfg(cfg), .pix_in(pix_in),
    .out_valid(sh_valid), .out_ready(sh_ready), .out_word(sh_word)
  );

  hgsp_grain u_grain (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(sh_valid), .in_ready(sh_ready), .in_word(sh_word),
    .out_valid(gr_valid), .out_ready(gr_ready), .out_word(gr_word)
  );

  hgsp_out u_out (
    .clk(clk), .rst(rst),
    .in_valid(gr_valid), .in_ready(gr_ready), .in_word(gr_word),
    .pix_out(pix_out)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/hgsp_check.sv
`default_nettype none

module hgsp_check (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [hgsp_pkg::OUT_W-1:0]  red_out,
  input logic signed [hgsp_pkg::OUT_W-1:0]  green_out,
  input logic signed [hgsp_pkg::OUT_W-1:0]  blue_out
);
  import hgsp_pkg::*;

  logic       in_acc, out_acc;
  logic [4:0] inflight;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 5'(in_acc) - 5'(out_acc);
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(green_out)
      && $stable(blue_out))
    else $error("output word changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != 5'd0)
    else $error("output word with no pixel in flight");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= 5'(PIPE_DEPTH))
    else $error("more pixels in flight than pipeline stages");

  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind hashed_grain_shake_pixel_post_core hgsp_check u_hgsp_check (
  .clk(clk), .rst(rst),
  .in_valid(pix_in.valid), .in_ready(pix_in.ready),
  .out_valid(pix_out.valid), .out_ready(pix_out.ready),
  .red_out(pix_out.red_out), .green_out(pix_out.green_out), .blue_out(pix_out.blue_out)
);

`default_nettype wire
